FILE: rtl/crm_pkg.sv
// Shared types and constants for the rotor map-and-step block.
// Used by crm_ctrl, crm_dp and the top level; no dependencies.
`default_nettype none

package crm_pkg;

    // Alphabet and field widths
    localparam int ALPHA_SIZE   = 26;
    localparam int LETTER_W     = 5;
    localparam int WIRE_W       = 60;
    localparam int WIRE3_W      = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 60;
    localparam int IN_TDATA_W   = 8;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 16;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_FWD     = 2'd0,
        OP_BWD     = 2'd1,
        OP_STEP    = 2'd2,
        OP_RESTART = 2'd3
    } op_e_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIRING_FIRST  = 3'd0,
        REG_WIRING_SECOND = 3'd1,
        REG_WIRING_THIRD  = 3'd2,
        REG_NOTCH_MASK    = 3'd3,
        REG_START_POS     = 3'd4
    } cfg_reg_e_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_FWD  = 2'd1,
        ST_SCAN = 2'd2,
        ST_DONE = 2'd3
    } state_e_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic calc_addr;
        logic scan_en;
        logic finish;
    } crm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_e_t in_op;
        logic  scan_last;
        logic  out_free;
    } crm_status_t;

endpackage

`default_nettype wire

FILE: rtl/crm_ctrl.sv
// Controller state machine for the rotor block.
// Depends on crm_pkg for state, command and status types.
`default_nettype none

module crm_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire crm_pkg::crm_status_t status,
    output crm_pkg::crm_cmd_t    cmd
);
    import crm_pkg::*;

    state_e_t state_reg;
    state_e_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through accept, address or scan where the opcode needs one, and finish
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    case (status.in_op)
                        OP_FWD:  state_next = ST_FWD;
                        OP_BWD:  state_next = ST_SCAN;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_FWD:
            begin
                cmd.calc_addr = 1'b1;
                state_next    = ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/crm_dp.sv
// Datapath for the rotor block: configuration registers, position,
// wiring lookup, backward scan and output register. Depends on crm_pkg.
`default_nettype none

module crm_dp (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire crm_pkg::crm_cmd_t               cmd,
    output crm_pkg::crm_status_t                 status,
    input  wire                                  cfg_valid,
    input  wire  [crm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [crm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire  [crm_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  wire  [crm_pkg::IN_TUSER_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [crm_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import crm_pkg::*;

    localparam logic [5:0] N6 = 6'(ALPHA_SIZE);

    // Reduce a value below 64 into the alphabet
    function automatic logic [LETTER_W-1:0] mod_alpha(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        if (t >= N6)
        begin
            t = t - N6;
        end
        if (t >= N6)
        begin
            t = t - N6;
        end
        return t[LETTER_W-1:0];
    endfunction

    logic [WIRE_W-1:0]     wiring_first_reg;
    logic [WIRE_W-1:0]     wiring_second_reg;
    logic [WIRE3_W-1:0]    wiring_third_reg;
    logic [ALPHA_SIZE-1:0] notch_mask_reg;
    logic [LETTER_W-1:0]   start_pos_reg;

    logic [LETTER_W-1:0]   rotor_pos_reg;
    op_e_t                 op_reg;
    logic [LETTER_W-1:0]   letter_reg;
    logic [LETTER_W-1:0]   addr_reg;
    logic [LETTER_W-1:0]   scan_cnt_reg;
    logic                  found_reg;
    logic [LETTER_W-1:0]   match_idx_reg;

    logic                  out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [LETTER_W-1:0]   wire_ent [0:ALPHA_SIZE-1];
    logic [LETTER_W-1:0]   rd_addr;
    logic [LETTER_W-1:0]   rd_entry;
    logic [LETTER_W-1:0]   res_letter;
    logic [LETTER_W-1:0]   pos_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiring_first_reg  <= '0;
            wiring_second_reg <= '0;
            wiring_third_reg  <= '0;
            notch_mask_reg    <= '0;
            start_pos_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_e_t'(cfg_index))
                REG_WIRING_FIRST:  wiring_first_reg  <= cfg_data[WIRE_W-1:0];
                REG_WIRING_SECOND: wiring_second_reg <= cfg_data[WIRE_W-1:0];
                REG_WIRING_THIRD:  wiring_third_reg  <= cfg_data[WIRE3_W-1:0];
                REG_NOTCH_MASK:    notch_mask_reg    <= cfg_data[ALPHA_SIZE-1:0];
                REG_START_POS:     start_pos_reg     <= cfg_data[LETTER_W-1:0];
                default:           ;
            endcase
        end
    end

    // Unpack the wiring entries
    always_comb
    begin
        for (int k = 0; k < ALPHA_SIZE; k++)
        begin
            if (k < 12)
            begin
                wire_ent[k] = wiring_first_reg[5*k +: 5];
            end
            else if (k < 24)
            begin
                wire_ent[k] = wiring_second_reg[5*(k-12) +: 5];
            end
            else
            begin
                wire_ent[k] = wiring_third_reg[5*(k-24) +: 5];
            end
        end
    end

    // Single lookup port: scan counter while scanning, forward address otherwise
    assign rd_addr  = cmd.scan_en ? scan_cnt_reg : addr_reg;
    assign rd_entry = (rd_addr < LETTER_W'(ALPHA_SIZE)) ? wire_ent[rd_addr] : '0;

    // Latch the item, form the forward address, run the backward scan
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= op_e_t'(s_tuser);
            letter_reg <= s_tdata[LETTER_W-1:0];
        end
        if (cmd.calc_addr)
        begin
            addr_reg <= mod_alpha(6'(letter_reg) + 6'(rotor_pos_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg  <= '0;
            found_reg     <= 1'b0;
            match_idx_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            scan_cnt_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
            if (rd_entry == letter_reg)
            begin
                found_reg     <= 1'b1;
                match_idx_reg <= scan_cnt_reg;
            end
        end
    end

    // Result letter and new position for the finishing cycle
    always_comb
    begin
        res_letter = '0;
        pos_next   = rotor_pos_reg;
        case (op_reg)
            OP_FWD:
            begin
                res_letter = mod_alpha(6'(rd_entry));
            end
            OP_BWD:
            begin
                if (found_reg)
                begin
                    res_letter = mod_alpha(6'(match_idx_reg) + N6 - 6'(rotor_pos_reg));
                end
                else
                begin
                    res_letter = mod_alpha(6'(letter_reg));
                end
            end
            OP_STEP:
            begin
                pos_next = (rotor_pos_reg == LETTER_W'(ALPHA_SIZE - 1)) ? '0
                         : rotor_pos_reg + 1'b1;
            end
            OP_RESTART:
            begin
                pos_next = mod_alpha(6'(start_pos_reg));
            end
            default:
            begin
                res_letter = '0;
            end
        endcase
    end

    // Commit the position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_pos_reg <= '0;
        end
        else if (cmd.finish)
        begin
            rotor_pos_reg <= pos_next;
        end
    end

    // Output register: load on finish, drop on a taken transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {5'd0, notch_mask_reg[pos_next], pos_next, res_letter};
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;
    assign status.in_op     = op_e_t'(s_tuser);
    assign status.scan_last = (scan_cnt_reg == LETTER_W'(ALPHA_SIZE - 1));
    assign status.out_free  = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

FILE: rtl/cipher_rotor_map_and_step.sv
// Top level of one cipher rotor: controller plus datapath.
// Depends on crm_pkg, crm_ctrl and crm_dp.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid/s_tready    tdata: letter_in; tuser: opcode
//  m_*      out        m_tvalid/m_tready    tdata: letter_out, rotor_position, at_notch
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Forward map runs accept, address, finish; step and restart run accept,
// finish; backward map walks the 26 wiring entries through one comparator.
// One item is in work at a time; a new item is taken while a result waits.
// A stalled output holds the block in its finishing cycle until taken.
// rst_n clears position, configuration and control asynchronously.
`default_nettype none

module cipher_rotor_map_and_step (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [crm_pkg::IN_TDATA_W-1:0]       s_tdata,   // [4:0] letter_in, [7:5] zero
    input  wire  [crm_pkg::IN_TUSER_W-1:0]       s_tuser,   // [1:0] opcode
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // [4:0] letter_out, [9:5] rotor_position, [10] at_notch, [15:11] zero
    output logic [crm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [crm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [crm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import crm_pkg::*;

    crm_cmd_t    cmd;
    crm_status_t status;

    assign cfg_ready = 1'b1;

    crm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    crm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/crm_checker.sv
// Port-level checks for the rotor block, bound to the top level.
// Depends on crm_pkg for widths.
`default_nettype none

module crm_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  s_tvalid,
    input wire                                  s_tready,
    input wire                                  m_tvalid,
    input wire                                  m_tready,
    input wire [crm_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import crm_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Position stays inside the alphabet
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[9:5] < 5'(ALPHA_SIZE))
        else $error("rotor position out of range");

    // Mapped letter stays inside the alphabet
    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[4:0] < 5'(ALPHA_SIZE))
        else $error("letter out of range");

    // One item at a time: ready drops after an accepted transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind cipher_rotor_map_and_step crm_checker u_crm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
